[rtl/jpp_pkg.sv]
// constants and helpers for the joystick packet parser
package jpp_pkg;

  // default number of data bytes after the sync byte
  localparam int unsigned PACKET_BYTES_DEF = 7;

  // data bytes that feed the held values (four sticks, buttons, ext)
  localparam int unsigned BUF_USED = 6;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SUM_TARGET = 8'hFF;
  localparam logic [7:0] STICK_BIAS = 8'h80;

  // stick byte to signed value, byte minus 128
  function automatic logic signed [7:0] stick(input logic [7:0] b);
    stick = $signed(b ^ STICK_BIAS);
  endfunction

endpackage

[rtl/joystick_packet_parser.sv]
// joystick packet parser: sync search, byte collection, checksum, held values
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | in_rx_byte
//   out     | out_valid / out_ready | out_packet_ok, four sticks, pan, tilt,
//           |                       | out_button_bits, out_extended_code
//   cfg     | cfg_valid / cfg_ready | cfg_left_handed_mode
//
// One received byte per cycle while the input does not stall. Each item goes
// into an input register and is parsed from there; the item that ends a
// packet loads the result register when it advances, so a result passes the
// input register and then the result register after its last byte is accepted.
// Reset (synchronous, rst_n low) leaves the parser waiting for sync with all
// held values zero. An unread result stalls only the byte that ends the next
// packet and the bytes behind it; other bytes keep flowing. cfg_ready is always high.
module joystick_packet_parser #(
  parameter int unsigned PACKET_BYTES = jpp_pkg::PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  // parsed packets
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_packet_ok,
  output logic signed [7:0] out_walk_vertical,
  output logic signed [7:0] out_walk_horizontal,
  output logic signed [7:0] out_look_vertical,
  output logic signed [7:0] out_look_horizontal,
  output logic [15:0]       out_pan_position,
  output logic [15:0]       out_tilt_position,
  output logic [7:0]        out_button_bits,
  output logic [7:0]        out_extended_code,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_left_handed_mode
);

  localparam int unsigned POS_W    = $clog2(PACKET_BYTES);
  localparam int unsigned CMP_W    = POS_W + 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  // input register
  logic             in_vld_r;
  logic [7:0]       in_byte_r;

  // parser state
  logic             waiting_r;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       sum_r;
  logic [7:0]       buf_r [jpp_pkg::BUF_USED];
  logic             lefty_r;

  // result register and held values
  logic             out_vld_r;
  logic             ok_r;
  logic signed [7:0] walk_v_r, walk_h_r, look_v_r, look_h_r;
  logic [15:0]      pan_r, tilt_r;
  logic [7:0]       buttons_r, ext_r;

  // parse decode
  logic             is_sync;
  logic             take_data;
  logic             ends_packet;
  logic             out_free;
  logic             advance;
  logic [7:0]       sum_nxt;
  logic             good_pkt;
  logic [7:0]       view [jpp_pkg::BUF_USED];

  always_comb begin
    is_sync     = (in_byte_r == jpp_pkg::SYNC_BYTE);
    take_data   = !waiting_r && !((pos_r == '0) && is_sync);
    ends_packet = in_vld_r && take_data && (pos_r == LAST_POS);
    out_free    = !out_vld_r || out_ready;
    advance     = in_vld_r && (!ends_packet || out_free);
    sum_nxt     = sum_r + in_byte_r;
    good_pkt    = (sum_nxt == jpp_pkg::SUM_TARGET);
    // buffer as it stands with the current byte written in
    for (int i = 0; i < int'(jpp_pkg::BUF_USED); i++) begin
      view[i] = ({3'b000, pos_r} == CMP_W'(i)) ? in_byte_r : buf_r[i];
    end
  end

  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lefty_r <= 1'b0;
    end else if (cfg_valid) begin
      lefty_r <= cfg_left_handed_mode;
    end
  end

  // frame position, running sum and sync search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b1;
      pos_r     <= '0;
      sum_r     <= '0;
    end else if (advance) begin
      if (waiting_r) begin
        if (is_sync) begin
          waiting_r <= 1'b0;
          pos_r     <= '0;
          sum_r     <= '0;
        end
      end else if (take_data) begin
        sum_r <= sum_nxt;
        if (pos_r == LAST_POS) begin
          waiting_r <= 1'b1;
          pos_r     <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // byte buffer, cleared at each sync so missing bytes read as zero
  always_ff @(posedge clk) begin
    if (advance) begin
      if (waiting_r && is_sync) begin
        for (int i = 0; i < int'(jpp_pkg::BUF_USED); i++) begin
          buf_r[i] <= '0;
        end
      end else if (take_data) begin
        for (int i = 0; i < int'(jpp_pkg::BUF_USED); i++) begin
          buf_r[i] <= view[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      ok_r      <= 1'b0;
    end else if (advance && ends_packet) begin
      out_vld_r <= 1'b1;
      ok_r      <= good_pkt;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // held values, loaded by a good packet only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_v_r  <= '0;
      walk_h_r  <= '0;
      look_v_r  <= '0;
      look_h_r  <= '0;
      pan_r     <= '0;
      tilt_r    <= '0;
      buttons_r <= '0;
      ext_r     <= '0;
    end else if (advance && ends_packet && good_pkt) begin
      if (lefty_r) begin
        walk_v_r <= jpp_pkg::stick(view[0]);
        walk_h_r <= jpp_pkg::stick(view[1]);
        look_v_r <= jpp_pkg::stick(view[2]);
        look_h_r <= jpp_pkg::stick(view[3]);
      end else begin
        look_v_r <= jpp_pkg::stick(view[0]);
        look_h_r <= jpp_pkg::stick(view[1]);
        walk_v_r <= jpp_pkg::stick(view[2]);
        walk_h_r <= jpp_pkg::stick(view[3]);
      end
      pan_r     <= {view[0], view[1]};
      tilt_r    <= {view[2], view[3]};
      buttons_r <= view[4];
      ext_r     <= view[5];
    end
  end

  assign out_valid           = out_vld_r;
  assign out_packet_ok       = ok_r;
  assign out_walk_vertical   = walk_v_r;
  assign out_walk_horizontal = walk_h_r;
  assign out_look_vertical   = look_v_r;
  assign out_look_horizontal = look_h_r;
  assign out_pan_position    = pan_r;
  assign out_tilt_position   = tilt_r;
  assign out_button_bits     = buttons_r;
  assign out_extended_code   = ext_r;

  // while waiting for sync the frame position stays at the start
  a_wait_pos: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> (pos_r == '0))
    else $error("frame position moved while waiting for sync");

  // a packet end raises the result and returns to sync search
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ends_packet) |=> (out_vld_r && waiting_r))
    else $error("packet end did not give a result");

  // a bad packet leaves the pan, tilt, button and extended values as they were
  a_bad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ends_packet && !good_pkt) |=>
      ($stable(pan_r) && $stable(tilt_r) && $stable(buttons_r) && $stable(ext_r)))
    else $error("bad packet changed held values");

  // input stalls only behind a packet end waiting on the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && ends_packet && out_vld_r))
    else $error("input stalled without a pending result");

endmodule
